// ===== design/mtq_pkg.sv =====
// Shared constants, codes and pipeline payload types for the rotation matrix
// to quaternion core. No dependencies.
`timescale 1ns / 1ps

package mtq_pkg;

    // Number format: signed DW bits with FB fraction bits
    localparam int DW  = 16;
    localparam int FB  = 14;
    localparam int ONE = 1 << FB;

    // Derived widths
    localparam int AW  = DW + 3;           // trace and radicand, signed
    localparam int XW  = DW + 1 + FB;      // radicand shifted up by FB, unsigned
    localparam int RW  = (XW + 1) / 2;     // rounded root
    localparam int SW  = RW + 1;           // scale s = 2 * root
    localparam int NW  = DW + 1;           // off-diagonal sums and differences
    localparam int DDW = NW + FB;          // rounded dividend
    localparam int QB  = DDW - FB / 2 - 1; // quotient bits (s is at least 2^(FB/2+1))

    // Pipeline shape
    localparam int SQ_PER = 2;
    localparam int SQ_STG = (RW + SQ_PER - 1) / SQ_PER;
    localparam int DV_PER = 3;
    localparam int DV_STG = (QB + DV_PER - 1) / DV_PER;

    localparam logic [XW-1:0] SQ_B0 = XW'(1) << (2 * (RW - 1));

    // Branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    // Front end result: radicand and the three numerators in component order
    typedef struct packed {
        logic [XW-1:0]          rad;
        logic [2:0][NW-1:0]     num;
        logic [1:0]             br;
    } front_t;

    // Square root working state
    typedef struct packed {
        logic [XW-1:0]          x;
        logic [XW:0]            r;
        logic [XW-1:0]          b;
        logic [2:0][NW-1:0]     num;
        logic [1:0]             br;
    } sq_t;

    // Divider input
    typedef struct packed {
        logic [2:0][DDW-1:0]    dvd;
        logic [SW-1:0]          s;
        logic [2:0]             neg;
        logic [DW-1:0]          diag;
        logic [1:0]             br;
        logic                   deg;
    } post_t;

    // Divider working state
    typedef struct packed {
        logic [2:0][SW:0]       rem;
        logic [2:0][DDW-1:0]    dvd;
        logic [2:0][QB-1:0]     q;
        logic [SW-1:0]          s;
        logic [2:0]             neg;
        logic [DW-1:0]          diag;
        logic [1:0]             br;
        logic                   deg;
    } dv_t;

endpackage

// ===== design/mtq_sqrt.sv =====
// Pipelined bit-by-bit integer square root, SQ_PER steps per stage.
// Carries the numerators and branch code alongside. Depends on mtq_pkg.
`timescale 1ns / 1ps

module mtq_sqrt import mtq_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  front_t in_data,
    output logic   out_valid,
    output sq_t    out_data
);

    logic [SQ_STG-1:0] vld_reg;
    sq_t               st_reg  [SQ_STG];
    sq_t               st_in   [SQ_STG];
    sq_t               st_next [SQ_STG];

    // Load the first stage from the front end
    always_comb begin
        st_in[0].x   = in_data.rad;
        st_in[0].r   = '0;
        st_in[0].b   = SQ_B0;
        st_in[0].num = in_data.num;
        st_in[0].br  = in_data.br;
    end

    genvar g;
    generate
        for (g = 0; g < SQ_STG; g++) begin : g_stage
            if (g > 0) begin : g_link
                assign st_in[g] = st_reg[g-1];
            end

            // Run this stage's root steps
            always_comb begin
                sq_t          cur;
                logic [XW:0]  t;
                cur = st_in[g];
                t   = '0;
                for (int j = 0; j < SQ_PER; j++) begin
                    if (g * SQ_PER + j < RW) begin
                        t = cur.r + {1'b0, cur.b};
                        if ({1'b0, cur.x} >= t) begin
                            cur.x = cur.x - t[XW-1:0];
                            cur.r = (cur.r >> 1) + {1'b0, cur.b};
                        end else begin
                            cur.r = cur.r >> 1;
                        end
                        cur.b = cur.b >> 2;
                    end
                end
                st_next[g] = cur;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[g] <= st_next[g];
                end
            end
        end
    endgenerate

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_STG-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[SQ_STG-1];
    assign out_data  = st_reg[SQ_STG-1];

endmodule

// ===== design/mtq_div.sv =====
// Three-lane pipelined restoring divider, DV_PER quotient bits per stage.
// Carries scale, signs, diagonal term and flags. Depends on mtq_pkg.
`timescale 1ns / 1ps

module mtq_div import mtq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  post_t in_data,
    output logic  out_valid,
    output dv_t   out_data
);

    logic [DV_STG-1:0] vld_reg;
    dv_t               st_reg  [DV_STG];
    dv_t               st_in   [DV_STG];
    dv_t               st_next [DV_STG];

    // Seed each lane's partial remainder with the dividend's top bits
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            st_in[0].rem[l] = (SW+1)'(in_data.dvd[l][DDW-1:QB]);
        end
        st_in[0].dvd  = in_data.dvd;
        st_in[0].q    = '0;
        st_in[0].s    = in_data.s;
        st_in[0].neg  = in_data.neg;
        st_in[0].diag = in_data.diag;
        st_in[0].br   = in_data.br;
        st_in[0].deg  = in_data.deg;
    end

    genvar g;
    generate
        for (g = 0; g < DV_STG; g++) begin : g_stage
            if (g > 0) begin : g_link
                assign st_in[g] = st_reg[g-1];
            end

            // Bring down one dividend bit per step and try the subtract
            always_comb begin
                dv_t         cur;
                logic [SW:0] t;
                logic        qb;
                cur = st_in[g];
                t   = '0;
                qb  = 1'b0;
                for (int j = 0; j < DV_PER; j++) begin
                    if (g * DV_PER + j < QB) begin
                        for (int l = 0; l < 3; l++) begin
                            t  = {cur.rem[l][SW-1:0], cur.dvd[l][QB-1]};
                            qb = (t >= {1'b0, cur.s});
                            cur.rem[l] = qb ? (t - {1'b0, cur.s}) : t;
                            cur.q[l]   = {cur.q[l][QB-2:0], qb};
                            cur.dvd[l] = cur.dvd[l] << 1;
                        end
                    end
                end
                st_next[g] = cur;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    st_reg[g] <= st_next[g];
                end
            end
        end
    endgenerate

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DV_STG-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DV_STG-1];
    assign out_data  = st_reg[DV_STG-1];

endmodule

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// Registered path (Q2.14 data): front end, square root stages, post stage, divider stages, output register.
// Throughput: one matrix per cycle unless m_tready stalls; every stage is registered and moves together.
// The whole pipeline holds while a result waits on m_tready; nothing is lost.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
// Top level of the rotation matrix to quaternion core.
// Depends on mtq_pkg, mtq_sqrt and mtq_div.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core import mtq_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (DW bits each)
    input  logic [9*DW-1:0] s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // qx, qy, qz, qw (DW bits each)
    output logic [4*DW-1:0] m_tdata,
    // branch_taken [1:0], degenerate [2]
    output logic [2:0]      m_tuser
);

    localparam logic [QB-1:0] Q_POS_MAX = QB'((1 << (DW - 1)) - 1);
    localparam logic [QB-1:0] Q_NEG_MAX = QB'(1 << (DW - 1));
    localparam logic [DW-1:0] D_MAX     = DW'((1 << (DW - 1)) - 1);
    localparam logic [DW-1:0] D_MIN     = DW'(1 << (DW - 1));

    logic            en;
    logic            fr_vld_reg;
    front_t          fr_reg, fr_next;
    logic            sq_vld;
    sq_t             sq_out;
    logic            po_vld_reg;
    post_t           po_reg, po_next;
    logic            dv_vld;
    dv_t             dv_out;
    logic            m_tvalid_reg;
    logic [4*DW-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]      m_tuser_reg, m_tuser_next;

    // Whole pipeline advances unless the output holds an untaken transaction
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Front end: trace, branch pick, radicand, numerators
    always_comb begin
        logic signed [DW-1:0] m [9];
        logic signed [AW-1:0] trace, a;
        logic signed [NW-1:0] s01, s02, s12, dx, dy, dz;
        for (int i = 0; i < 9; i++) begin
            m[i] = s_tdata[i*DW +: DW];
        end
        trace = AW'(ONE) + AW'(m[0]) + AW'(m[4]) + AW'(m[8]);
        s01 = NW'(m[1]) + NW'(m[3]);
        s02 = NW'(m[2]) + NW'(m[6]);
        s12 = NW'(m[5]) + NW'(m[7]);
        dx  = NW'(m[7]) - NW'(m[5]);
        dy  = NW'(m[2]) - NW'(m[6]);
        dz  = NW'(m[3]) - NW'(m[1]);
        if (trace >= AW'(1)) begin
            fr_next.br = BR_TRACE;
            a = trace;
            fr_next.num = {dz, dy, dx};
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            fr_next.br = BR_X;
            a = AW'(ONE) + AW'(m[0]) - AW'(m[4]) - AW'(m[8]);
            fr_next.num = {dx, s02, s01};
        end else if (m[4] > m[8]) begin
            fr_next.br = BR_Y;
            a = AW'(ONE) + AW'(m[4]) - AW'(m[0]) - AW'(m[8]);
            fr_next.num = {dy, s12, s01};
        end else begin
            fr_next.br = BR_Z;
            a = AW'(ONE) + AW'(m[8]) - AW'(m[0]) - AW'(m[4]);
            fr_next.num = {dz, s12, s02};
        end
        // A non-positive radicand gives a zero root and so a zero scale
        if (!a[AW-1] && a != '0) begin
            fr_next.rad = {a[XW-FB-1:0], FB'(0)};
        end else begin
            fr_next.rad = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_vld_reg <= 1'b0;
        end else if (en) begin
            fr_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg <= fr_next;
        end
    end

    mtq_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_vld_reg),
        .in_data   (fr_reg),
        .out_valid (sq_vld),
        .out_data  (sq_out)
    );

    // Round the root, form scale and diagonal term, build rounded dividends
    always_comb begin
        logic [RW-1:0] rr;
        logic [SW-1:0] s;
        logic [SW:0]   ds;
        logic [NW-1:0] mag;
        if ({1'b0, sq_out.x} > sq_out.r) begin
            rr = sq_out.r[RW-1:0] + RW'(1);
        end else begin
            rr = sq_out.r[RW-1:0];
        end
        s  = {rr, 1'b0};
        ds = ({1'b0, s} + (SW+1)'(2)) >> 2;
        po_next.diag = (ds > (SW+1)'(D_MAX)) ? D_MAX : DW'(ds);
        po_next.s    = s;
        po_next.br   = sq_out.br;
        po_next.deg  = (rr == '0);
        for (int l = 0; l < 3; l++) begin
            po_next.neg[l] = sq_out.num[l][NW-1];
            mag = sq_out.num[l][NW-1] ? (NW'(0) - sq_out.num[l]) : sq_out.num[l];
            po_next.dvd[l] = {mag, FB'(0)} + DDW'(s >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            po_vld_reg <= 1'b0;
        end else if (en) begin
            po_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            po_reg <= po_next;
        end
    end

    mtq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (po_vld_reg),
        .in_data   (po_reg),
        .out_valid (dv_vld),
        .out_data  (dv_out)
    );

    // Apply signs, saturate, place components by branch; a degenerate result gives all zeros
    always_comb begin
        logic [2:0][DW-1:0] c;
        for (int l = 0; l < 3; l++) begin
            if (dv_out.neg[l]) begin
                c[l] = (dv_out.q[l] > Q_NEG_MAX) ? D_MIN : (DW'(0) - dv_out.q[l][DW-1:0]);
            end else begin
                c[l] = (dv_out.q[l] > Q_POS_MAX) ? D_MAX : dv_out.q[l][DW-1:0];
            end
        end
        case (dv_out.br)
            BR_TRACE: m_tdata_next = {dv_out.diag, c[2], c[1], c[0]};
            BR_X:     m_tdata_next = {c[2], c[1], c[0], dv_out.diag};
            BR_Y:     m_tdata_next = {c[2], c[1], dv_out.diag, c[0]};
            default:  m_tdata_next = {c[2], dv_out.diag, c[1], c[0]};
        endcase
        if (dv_out.deg) begin
            m_tdata_next = '0;
        end
        m_tuser_next = {dv_out.deg, dv_out.br};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for rotation_matrix_to_quaternion_core.
// Drives matrices over the input stream and checks each quaternion against an
// in-bench fixed point predictor. Depends on mtq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import mtq_pkg::*;

    typedef struct packed {
        logic [1:0]        br;
        logic              deg;
        logic [3:0][DW-1:0] q;   // q[0] = qx ... q[3] = qw
    } quat_t;

    typedef struct {
        logic [8:0][DW-1:0] m;
        bit                 typed;   // expected result given in the row
        quat_t              want;
    } row_t;

    logic            aclk;
    logic            aresetn;
    logic            s_tvalid;
    logic            s_tready;
    logic [9*DW-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [4*DW-1:0] m_tdata;
    logic [2:0]      m_tuser;

    quat_t expected_quats[$];
    row_t  rows[$];
    int    mismatches;
    bit    sending_done;
    bit    hold_off;

    rotation_matrix_to_quaternion_core u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Rounded square root of a nonnegative value
    function automatic longint unsigned sqrt_round(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (x > r) r++;
        return r;
    endfunction

    function automatic longint clamp_dw(longint v);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Signed fixed point quotient, nearest with ties away from zero
    function automatic longint scaled_quot(longint num, longint unsigned s);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        q = ((mag << FB) + (s >> 1)) / s;
        return clamp_dw((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic quat_t matrix_to_quat(logic [8:0][DW-1:0] mat);
        longint e[9];
        longint one_fx, tr, rad, diag, s01, s02, s12, dx, dy, dz;
        longint unsigned s;
        quat_t res;
        one_fx = longint'(1) << FB;
        for (int i = 0; i < 9; i++) e[i] = longint'(signed'(mat[i]));
        tr = one_fx + e[0] + e[4] + e[8];
        if (tr >= 1) begin
            res.br = BR_TRACE; rad = tr;
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            res.br = BR_X; rad = one_fx + e[0] - e[4] - e[8];
        end else if (e[4] > e[8]) begin
            res.br = BR_Y; rad = one_fx + e[4] - e[0] - e[8];
        end else begin
            res.br = BR_Z; rad = one_fx + e[8] - e[0] - e[4];
        end
        s = (rad > 0) ? 2 * sqrt_round(longint'(rad) << FB) : 0;
        res.deg = (s == 0);
        res.q = '0;
        if (s != 0) begin
            diag = clamp_dw(longint'((s + 2) >> 2));
            s01 = e[1] + e[3]; s02 = e[2] + e[6]; s12 = e[5] + e[7];
            dx = e[7] - e[5]; dy = e[2] - e[6]; dz = e[3] - e[1];
            case (res.br)
                BR_TRACE: begin
                    res.q[0] = DW'(scaled_quot(dx, s)); res.q[1] = DW'(scaled_quot(dy, s));
                    res.q[2] = DW'(scaled_quot(dz, s)); res.q[3] = DW'(diag);
                end
                BR_X: begin
                    res.q[0] = DW'(diag); res.q[1] = DW'(scaled_quot(s01, s));
                    res.q[2] = DW'(scaled_quot(s02, s)); res.q[3] = DW'(scaled_quot(dx, s));
                end
                BR_Y: begin
                    res.q[0] = DW'(scaled_quot(s01, s)); res.q[1] = DW'(diag);
                    res.q[2] = DW'(scaled_quot(s12, s)); res.q[3] = DW'(scaled_quot(dy, s));
                end
                default: begin
                    res.q[0] = DW'(scaled_quot(s02, s)); res.q[1] = DW'(scaled_quot(s12, s));
                    res.q[2] = DW'(diag); res.q[3] = DW'(scaled_quot(dz, s));
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [8:0][DW-1:0] diag_mat(int a, int b, int c);
        logic [8:0][DW-1:0] m;
        m = '0;
        m[0] = DW'(a); m[4] = DW'(b); m[8] = DW'(c);
        return m;
    endfunction

    function automatic quat_t quat(int x, int y, int z, int w, logic [1:0] br);
        quat_t r;
        r.q[0] = DW'(x); r.q[1] = DW'(y); r.q[2] = DW'(z); r.q[3] = DW'(w);
        r.br = br; r.deg = 1'b0;
        return r;
    endfunction

    task automatic add_row(logic [8:0][DW-1:0] m, bit typed, quat_t want);
        row_t r;
        r.m = m; r.typed = typed; r.want = want;
        rows.push_back(r);
    endtask

    function automatic logic [8:0][DW-1:0] random_mat();
        logic [8:0][DW-1:0] m;
        int k;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) begin
            // mostly plausible rotation ranges, sometimes full-range noise
            if (k == 0) m[i] = DW'($urandom);
            else m[i] = DW'($urandom_range(0, 2 * ONE) - ONE);
        end
        // steer the diagonal toward the X, Y or Z branch, or leave it as drawn
        case ($urandom_range(0, 4))
            1: begin m[0] = DW'(ONE / 2); m[4] = DW'(-ONE); m[8] = DW'(-ONE); end
            2: begin m[0] = DW'(-ONE); m[4] = DW'(ONE / 3); m[8] = DW'(-ONE); end
            3: begin m[0] = DW'(-ONE); m[4] = DW'(-ONE); m[8] = DW'(ONE / 4); end
            default: ;
        endcase
        return m;
    endfunction

    // Directed rows: identity and half-turns typed in, extremes predicted
    initial begin
        logic [8:0][DW-1:0] m;
        quat_t nq;
        nq = '0;
        add_row(diag_mat(ONE, ONE, ONE), 1, quat(0, 0, 0, ONE, BR_TRACE));
        add_row(diag_mat(ONE, -ONE, -ONE), 1, quat(ONE, 0, 0, 0, BR_X));
        add_row(diag_mat(-ONE, ONE, -ONE), 1, quat(0, ONE, 0, 0, BR_Y));
        add_row(diag_mat(-ONE, -ONE, ONE), 1, quat(0, 0, ONE, 0, BR_Z));
        add_row('0, 0, nq);
        add_row({9{DW'(16'h7fff)}}, 0, nq);
        add_row({9{DW'(16'h8000)}}, 0, nq);
        add_row({9{DW'(16'hffff)}}, 0, nq);
        add_row({9{DW'(16'h5555)}}, 0, nq);
        add_row({9{DW'(16'haaaa)}}, 0, nq);
        // trace exactly one LSB and exactly zero
        add_row(diag_mat(-ONE / 3, -ONE / 3, -ONE / 3), 0, nq);
        add_row(diag_mat(-ONE / 2, -ONE / 2, 0), 0, nq);
        // diagonal ties fall through to later branches
        add_row(diag_mat(-ONE, -ONE, -ONE), 0, nq);
        add_row(diag_mat(-ONE / 2, -ONE / 2, -ONE), 0, nq);
        // large off-diagonals with full-scale and with minus-one diagonals
        m = diag_mat(-32768, -32768, 32767);
        for (int i = 0; i < 9; i++) if (i % 4 != 0) m[i] = DW'((i % 2) ? 32767 : -32768);
        add_row(m, 0, nq);
        m = diag_mat(-ONE, -ONE, -ONE);
        for (int i = 0; i < 9; i++) if (i % 4 != 0) m[i] = DW'((i % 2) ? -32768 : 32767);
        add_row(m, 0, nq);
        for (int i = 0; i < 500; i++) add_row(random_mat(), 0, nq);
    end

    // Sender: bursts with gaps, expected result queued on acceptance
    initial begin
        int idx, burst;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        sending_done = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idx = 0;
        while (idx < rows.size()) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < rows.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= rows[idx].m;
                @(posedge aclk);
                if (s_tready) begin
                    expected_quats.push_back(rows[idx].typed ? rows[idx].want
                                                             : matrix_to_quat(rows[idx].m));
                    idx++;
                    burst--;
                end
            end
            // Drop valid only when a gap follows
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // Long hold-off once, early in the random stream, to fill the pipeline
    initial begin
        hold_off = 0;
        repeat (200) @(posedge aclk);
        hold_off = 1;
        repeat (80) @(posedge aclk);
        hold_off = 0;
    end

    // Receiver: stall pattern with quiet stretches
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) m_tready <= 1'b0;
            else if (($time / 2000) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge aclk) begin
        quat_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.q = m_tdata; got.br = m_tuser[1:0]; got.deg = m_tuser[2];
            if (expected_quats.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_quats.pop_front();
                for (int i = 0; i < 4; i++)
                    if (got.q[i] !== want.q[i])
                        report_mismatch($sformatf("q[%0d]", i), signed'(got.q[i]),
                                        signed'(want.q[i]));
                if (got.br !== want.br) report_mismatch("branch_taken", got.br, want.br);
                if (got.deg !== want.deg) report_mismatch("degenerate", got.deg, want.deg);
            end
        end
    end

    initial begin
        mismatches = 0;
        wait (sending_done);
        while (expected_quats.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
design/mtq_pkg.sv
design/mtq_sqrt.sv
design/mtq_div.sv
design/rotation_matrix_to_quaternion_core.sv
test/tb.sv
